/* hdl/fcde_pkg.sv */
package fcde_pkg;

  localparam int MAX_RECORD_BYTES_DEF = 512;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 10;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_RECORD_LENGTH = 3'd0;
  localparam logic [LEN_W-1:0]  RESET_RECORD_LEN  = 10'd16;

  // header coding
  localparam logic [LEN_W-1:0]  HDR_SHORT_MAX = 10'd254;
  localparam logic [BYTE_W-1:0] HDR_ESCAPE    = 8'd255;

  // result queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;
  localparam int MAX_RES  = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              new_run;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              record_end;
    logic              duplicate;
  } out_beat_t;

endpackage

/* hdl/fcde_ram.sv */
module fcde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/front_coding_dedup_encoder.sv */
// channel | ports                              | beat
// input   | in_valid, in_stall, in_data        | one record byte + run-start flag
// output  | out_valid, out_stall, out_data     | header/record byte or duplicate marker
// config  | cfg_psel/penable/pwrite/paddr/...  | record_length at byte address 0
//
// Takes one input beat per cycle while in_stall is low. Each byte reads the stored previous record
// (registered RAM read) and is compared and written back at the compare stage.
// A mismatch byte yields 2 or 4 output beats, drained one per cycle while out_stall is
// low, from an 8-entry queue; in_stall rises while a byte waits at the compare stage
// and more than 4 beats are queued. Synchronous reset clears position and queue, sets
// the match flag and length (16); the record store is not cleared.
module front_coding_dedup_encoder #(
  parameter int MAX_RECORD_BYTES = fcde_pkg::MAX_RECORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fcde_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fcde_pkg::out_beat_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fcde_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fcde_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fcde_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import fcde_pkg::*;

  localparam int AW = $clog2(MAX_RECORD_BYTES);

  logic [LEN_W-1:0]  record_length_r;
  logic [LEN_W-1:0]  len_eff, len_m1, pos_use;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              in_last, in_accept;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [LEN_W-1:0]  s1_pos_r;
  logic              s1_last_r, s1_start_r;
  logic              fwd_hit_r;
  logic [BYTE_W-1:0] fwd_byte_r;
  logic              s1_fire;

  logic              matching_r, matching_nxt;
  logic [BYTE_W-1:0] stored, ram_rdata;
  logic              differs, s1_we, ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  out_beat_t         res [MAX_RES];
  logic [2:0]        res_n;

  out_beat_t         oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wr_r, oq_rd_r;
  logic [OQ_AW:0]    oq_cnt_r, oq_cnt_nxt;
  logic              oq_pop;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_RECORD_LENGTH) ? CFG_DW'(record_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_length_r <= RESET_RECORD_LEN;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_RECORD_LENGTH) begin
      record_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    if (record_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(record_length_r) > 32'(MAX_RECORD_BYTES)) begin
      len_eff = LEN_W'(MAX_RECORD_BYTES);
    end else begin
      len_eff = record_length_r;
    end
  end

  assign len_m1  = len_eff - LEN_W'(1);
  assign pos_use = (pos_r > len_m1) ? len_m1 : pos_r;
  assign in_last = (pos_use == len_m1);

  // stage 0: accept, issue store read
  assign s1_fire   = s1_valid_r && (oq_cnt_r <= (OQ_AW+1)'(OQ_DEPTH - MAX_RES));
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;
  assign pos_nxt   = in_accept ? (in_last ? '0 : pos_use + LEN_W'(1)) : pos_r;
  assign ram_raddr = AW'(pos_use);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
      matching_r <= 1'b1;
    end else begin
      pos_r      <= pos_nxt;
      s1_valid_r <= s1_valid_nxt;
      matching_r <= matching_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_data.data_byte;
      s1_pos_r   <= pos_use;
      s1_last_r  <= in_last;
      s1_start_r <= in_data.new_run && (pos_use == '0);
      // same-cycle write to the entry being read
      fwd_hit_r  <= ram_we && (ram_waddr == ram_raddr);
      fwd_byte_r <= s1_byte_r;
    end
  end

  // stage 1: compare, emit, write back
  assign stored  = fwd_hit_r ? fwd_byte_r : ram_rdata;
  assign differs = s1_start_r || (stored != s1_byte_r);

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    res_n        = 3'd0;
    s1_we        = 1'b0;
    matching_nxt = matching_r;
    if (s1_fire) begin
      if (matching_r) begin
        if (differs) begin
          matching_nxt = 1'b0;
          s1_we        = 1'b1;
          if (s1_pos_r > HDR_SHORT_MAX) begin
            res[0] = '{out_byte: HDR_ESCAPE, byte_valid: 1'b1,
                       record_end: 1'b0, duplicate: 1'b0};
            res[1] = '{out_byte: s1_pos_r[7:0], byte_valid: 1'b1,
                       record_end: 1'b0, duplicate: 1'b0};
            res[2] = '{out_byte: BYTE_W'(s1_pos_r >> 8), byte_valid: 1'b1,
                       record_end: 1'b0, duplicate: 1'b0};
            res[3] = '{out_byte: s1_byte_r, byte_valid: 1'b1,
                       record_end: 1'b0, duplicate: 1'b0};
            res_n  = 3'd4;
          end else begin
            res[0] = '{out_byte: s1_pos_r[7:0], byte_valid: 1'b1,
                       record_end: 1'b0, duplicate: 1'b0};
            res[1] = '{out_byte: s1_byte_r, byte_valid: 1'b1,
                       record_end: 1'b0, duplicate: 1'b0};
            res_n  = 3'd2;
          end
        end else if (s1_last_r) begin
          res[0] = '{out_byte: '0, byte_valid: 1'b0, record_end: 1'b0, duplicate: 1'b1};
          res_n  = 3'd1;
        end
      end else begin
        s1_we  = 1'b1;
        res[0] = '{out_byte: s1_byte_r, byte_valid: 1'b1, record_end: 1'b0, duplicate: 1'b0};
        res_n  = 3'd1;
      end
      if (s1_last_r) begin
        matching_nxt = 1'b1;
        for (int i = 0; i < MAX_RES; i++) begin
          if (3'(i) == res_n - 3'd1) begin
            res[i].record_end = 1'b1;
          end
        end
      end
    end
  end

  assign ram_we    = s1_we;
  assign ram_waddr = AW'(s1_pos_r);

  fcde_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_RECORD_BYTES)
  ) u_prev_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_byte_r),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result queue
  assign out_valid  = (oq_cnt_r != '0);
  assign out_data   = oq_mem_r[oq_rd_r];
  assign oq_pop     = out_valid && !out_stall;
  assign oq_cnt_nxt = oq_cnt_r + (OQ_AW+1)'(res_n) - (OQ_AW+1)'(oq_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_r + OQ_AW'(res_n);
      oq_rd_r  <= oq_rd_r + OQ_AW'(oq_pop);
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < res_n) begin
        oq_mem_r[oq_wr_r + OQ_AW'(i)] <= res[i];
      end
    end
  end

endmodule

/* hdl/fcde_chk.sv */
module fcde_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input fcde_pkg::out_beat_t out_data
);

  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // duplicate marker carries no byte and closes its record
  a_dup_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.duplicate |->
      !out_data.byte_valid && out_data.record_end && out_data.out_byte == '0)
    else $error("malformed duplicate marker");

  a_byteless_is_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.duplicate)
    else $error("output beat without byte or marker");

endmodule

bind front_coding_dedup_encoder fcde_chk u_fcde_chk (.*);

/* sim/tb_front_coding_dedup_encoder.sv */
module tb_front_coding_dedup_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import fcde_pkg::*;

  localparam int MAX_BYTES = MAX_RECORD_BYTES_DEF;
  localparam int RAND_BYTES = 210;

  typedef enum int {REC_FRESH, REC_DUP, REC_MISS, REC_NOISE} rec_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  front_coding_dedup_encoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // encoder state as seen by the predictor
  logic [BYTE_W-1:0] prev_rec [MAX_BYTES];
  int enc_pos = 0;
  bit enc_matching = 1'b1;
  logic [LEN_W-1:0] enc_len = RESET_RECORD_LEN;

  // stimulus side shadow of the record store
  logic [BYTE_W-1:0] gen_rec [MAX_BYTES];
  int gen_pos = 0;
  int gen_len = 16;

  in_beat_t byte_feed_q [$];
  out_beat_t encoded_q [$];

  int idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int errors = 0;
  int bytes_fed = 0;
  int bytes_in = 0;
  int beats_out = 0;
  int n_dup = 0;
  int n_escape = 0;
  int n_settings = 0;

  function automatic int clamp_len(logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_BYTES) return MAX_BYTES;
    return int'(v);
  endfunction

  function automatic out_beat_t data_beat(logic [BYTE_W-1:0] v);
    return '{out_byte: v, byte_valid: 1'b1, record_end: 1'b0, duplicate: 1'b0};
  endfunction

  task automatic encode_byte(in_beat_t beat);
    out_beat_t res [$];
    out_beat_t r;
    int len;
    int p;
    bit last;
    len = clamp_len(enc_len);
    p = (enc_pos >= len) ? len - 1 : enc_pos;
    last = (p == len - 1);
    if (enc_matching) begin
      if ((p == 0 && beat.new_run) || prev_rec[p] != beat.data_byte) begin
        enc_matching = 1'b0;
        if (p > HDR_SHORT_MAX) begin
          res.push_back(data_beat(HDR_ESCAPE));
          res.push_back(data_beat(p[7:0]));
          res.push_back(data_beat({6'b0, p[9:8]}));
          n_escape++;
        end else begin
          res.push_back(data_beat(p[7:0]));
        end
        res.push_back(data_beat(beat.data_byte));
        prev_rec[p] = beat.data_byte;
      end else if (last) begin
        res.push_back('{out_byte: '0, byte_valid: 1'b0, record_end: 1'b0, duplicate: 1'b1});
        n_dup++;
      end
    end else begin
      res.push_back(data_beat(beat.data_byte));
      prev_rec[p] = beat.data_byte;
    end
    if (last) begin
      enc_pos = 0;
      enc_matching = 1'b1;
    end else begin
      enc_pos = p + 1;
    end
    foreach (res[i]) begin
      r = res[i];
      r.record_end = last && (i == res.size() - 1);
      encoded_q.push_back(r);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(in_data);
        bytes_in++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_feed_q.size() != 0) begin
          in_data <= byte_feed_q.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 99) < idle_pct) in_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (encoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected beat byte=%02h valid=%b end=%b dup=%b", $realtime,
                     out_data.out_byte, out_data.byte_valid, out_data.record_end,
                     out_data.duplicate);
        end else begin
          exp_beat = encoded_q.pop_front();
          if (out_data.out_byte !== exp_beat.out_byte ||
              out_data.byte_valid !== exp_beat.byte_valid ||
              out_data.record_end !== exp_beat.record_end ||
              out_data.duplicate !== exp_beat.duplicate) begin
            errors++;
            if (errors <= 10)
              $display("%0t: beat %0d byte/valid/end/dup expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                       $realtime, beats_out, exp_beat.out_byte, exp_beat.byte_valid,
                       exp_beat.record_end, exp_beat.duplicate, out_data.out_byte,
                       out_data.byte_valid, out_data.record_end, out_data.duplicate);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_gap = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_byte(logic [BYTE_W-1:0] v, logic nr);
    int p;
    p = (gen_pos >= gen_len) ? gen_len - 1 : gen_pos;
    byte_feed_q.push_back('{data_byte: v, new_run: nr});
    gen_rec[p] = v;
    gen_pos = (p == gen_len - 1) ? 0 : p + 1;
    bytes_fed++;
  endtask

  // sends the rest of the current record, at most nbytes of it
  task automatic gen_record(rec_mode_t mode, int miss_at, int nbytes);
    int p;
    int b;
    logic [BYTE_W-1:0] v;
    logic nr;
    p = (gen_pos >= gen_len) ? gen_len - 1 : gen_pos;
    if (mode == REC_FRESH && p != 0) mode = REC_NOISE;
    b = (miss_at >= p && miss_at < gen_len) ? miss_at : $urandom_range(p, gen_len - 1);
    for (int i = p; i < gen_len && i - p < nbytes; i++) begin
      case (mode)
        REC_DUP: v = gen_rec[i];
        REC_MISS: begin
          if (i < b) v = gen_rec[i];
          else if (i == b) v = gen_rec[i] ^ 8'($urandom_range(1, 255));
          else v = 8'($urandom);
        end
        default: v = 8'($urandom);
      endcase
      if (i == 0) nr = (mode == REC_FRESH);
      else nr = ($urandom_range(0, 15) == 0);
      push_byte(v, nr);
    end
  endtask

  task automatic wait_idle();
    while (byte_feed_q.size() != 0 || in_valid || encoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(logic wr, logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= REG_RECORD_LENGTH;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_len(logic [LEN_W-1:0] v);
    logic [CFG_DW-1:0] rd;
    wait_idle();
    // a matching byte leaves nothing queued but may still be in the pipe
    repeat (10) @(posedge clk);
    apb_xfer(1'b1, CFG_DW'(v), rd);
    apb_xfer(1'b0, '0, rd);
    if (rd[LEN_W-1:0] !== v) begin
      errors++;
      if (errors <= 10)
        $display("%0t: record_length readback expected %0d, got %0d", $realtime, v,
                 rd[LEN_W-1:0]);
    end
    enc_len = v;
    gen_len = clamp_len(v);
    n_settings++;
  endtask

  initial begin
    int rand_start;
    int nrec;
    int r;
    int cut;
    logic [LEN_W-1:0] l;
    rec_mode_t mode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short records, short-header and marker cases
    idle_pct = 10;
    set_len(4);
    push_byte(8'h00, 1); push_byte(8'hFF, 0); push_byte(8'h80, 0); push_byte(8'h7F, 0);
    push_byte(8'h00, 0); push_byte(8'hFF, 0); push_byte(8'h80, 1); push_byte(8'h7F, 0);
    push_byte(8'h00, 0); push_byte(8'hFF, 0); push_byte(8'h81, 0); push_byte(8'h55, 0);
    push_byte(8'h00, 0); push_byte(8'hFF, 0); push_byte(8'h81, 0); push_byte(8'hAA, 0);
    push_byte(8'h01, 0); push_byte(8'hFF, 0); push_byte(8'h81, 0); push_byte(8'hAA, 0);
    push_byte(8'h01, 1); push_byte(8'hFF, 0); push_byte(8'h81, 0); push_byte(8'hAA, 0);
    set_len(1);
    push_byte(8'h01, 0); push_byte(8'hFE, 0);
    set_len(0);
    push_byte(8'hFE, 0); push_byte(8'h00, 1);
    // length shrinks under a partial record
    set_len(4);
    push_byte(8'h00, 0); push_byte(8'hFF, 0);
    set_len(2);
    push_byte(8'hFF, 0);
    set_len(4);
    push_byte(8'h00, 0); push_byte(8'h12, 0);
    set_len(1);
    push_byte(8'h34, 0);

    // clamped length; the partial record fills every entry later records compare
    idle_pct = 8;
    set_len(10'h3FF);
    gen_record(REC_FRESH, -1, 40);
    set_len(4);
    gen_record(REC_DUP, -1, MAX_BYTES);

    rand_start = bytes_fed;
    while (bytes_fed - rand_start < RAND_BYTES) begin
      r = $urandom_range(0, 2);
      idle_pct = (r == 0) ? 0 : (r == 1) ? 8 : 25;
      r = $urandom_range(0, 19);
      if (r == 0) l = 0;
      else if (r < 3) l = 1;
      else if (r < 15) l = LEN_W'($urandom_range(2, 12));
      else l = LEN_W'($urandom_range(13, 40));
      set_len(l);
      nrec = $urandom_range(3, 8);
      for (int k = 0; k < nrec && bytes_fed - rand_start < RAND_BYTES; k++) begin
        r = $urandom_range(0, 19);
        mode = (r < 3) ? REC_FRESH : (r < 8) ? REC_DUP : (r < 17) ? REC_MISS : REC_NOISE;
        cut = MAX_BYTES;
        if (k == nrec - 1 && gen_len > 1 && $urandom_range(0, 3) == 0)
          cut = $urandom_range(1, gen_len - 1);
        gen_record(mode, -1, cut);
      end
    end

    // closing stretch at full rate
    idle_pct = 0;
    set_len(8);
    for (int k = 0; k < 6; k++) begin
      r = $urandom_range(0, 3);
      mode = (r == 0) ? REC_FRESH : (r == 1) ? REC_DUP : REC_MISS;
      gen_record(mode, -1, MAX_BYTES);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d input bytes and %0d result beats over %0d length writes.",
             bytes_in, beats_out, n_settings);
    $display("Saw %0d duplicate markers and %0d escape headers.", n_dup, n_escape);
    if (errors == 0) begin
      $display("tb_front_coding_dedup_encoder: PASS");
    end else begin
      $display("tb_front_coding_dedup_encoder: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d beats still expected", encoded_q.size());
    $display("tb_front_coding_dedup_encoder: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/fcde_pkg.sv
hdl/fcde_ram.sv
hdl/front_coding_dedup_encoder.sv
hdl/fcde_chk.sv
sim/tb_front_coding_dedup_encoder.sv
